// File: hw/rtl/text_console_cell_store_defines.svh
// ----------------------------------------------------------------------------
// text_console_cell_store_defines
// Assertion macros for the text console cell store. Define ASSERT_OFF to
// compile every check to nothing.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CELL_STORE_DEFINES_SVH
`define TEXT_CONSOLE_CELL_STORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property at every rising edge outside reset.
`define TCCS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition in one cycle leads to another in the next cycle.
`define TCCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TCCS_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: hw/rtl/tccs_pkg.sv
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared widths, character codes, op codes and register indexes of the
// text console cell store.
// ----------------------------------------------------------------------------
package tccs_pkg;

  localparam int OP_W       = 2;
  localparam int CODE_W     = 8;
  localparam int RROW_W     = 5;
  localparam int RCOL_W     = 7;
  localparam int CROW_W     = 6;
  localparam int CCOL_W     = 8;
  localparam int ROWS_CFG_W = 6;
  localparam int COLS_CFG_W = 8;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [CODE_W-1:0]     CODE_NEWLINE  = 8'd10;
  localparam logic [CODE_W-1:0]     CODE_SPACE    = 8'd32;
  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET    = 6'd28;
  localparam logic [COLS_CFG_W-1:0] COLUMNS_RESET = 8'd84;

  typedef enum logic [OP_W-1:0] {
    OP_PUT       = 2'd0,
    OP_BACKSPACE = 2'd1,
    OP_READ      = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  typedef enum logic {
    REG_ROWS    = 1'b0,
    REG_COLUMNS = 1'b1
  } reg_idx_t;

  // Outcome of one put: scroll first, then store a code.
  typedef struct packed {
    logic scroll;
    logic write_cell;
  } put_flags_t;

endpackage

// File: hw/rtl/tccs_chan_if.sv
// ----------------------------------------------------------------------------
// tccs_chan_if
// Valid/ready channels of the text console: the command item channel and
// the result item channel.
// ----------------------------------------------------------------------------
interface tccs_in_if import tccs_pkg::*; ();
  logic              valid;
  logic              ready;
  op_t               op;
  logic [CODE_W-1:0] char_code;
  logic [RROW_W-1:0] read_row;
  logic [RCOL_W-1:0] read_column;

  modport source (output valid, op, char_code, read_row, read_column, input ready);
  modport sink   (input valid, op, char_code, read_row, read_column, output ready);
endinterface

interface tccs_out_if import tccs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] cell_code;
  logic [CROW_W-1:0] cursor_row_now;
  logic [CCOL_W-1:0] cursor_column_now;
  logic              did_scroll;

  modport source (output valid, cell_code, cursor_row_now, cursor_column_now, did_scroll,
                  input ready);
  modport sink   (input valid, cell_code, cursor_row_now, cursor_column_now, did_scroll,
                  output ready);
endinterface

// File: hw/rtl/tccs_cell_mem.sv
// ----------------------------------------------------------------------------
// tccs_cell_mem
// Character cell memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tccs_cell_mem import tccs_pkg::*; #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [CODE_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [CODE_W-1:0] rdata
);

  logic [CODE_W-1:0] mem_r [DEPTH];
  logic [CODE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/tccs_cfg_regs.sv
// ----------------------------------------------------------------------------
// tccs_cfg_regs
// APB register file for the screen size, with the saturated row and
// column counts the datapath works with.
// ----------------------------------------------------------------------------
module tccs_cfg_regs import tccs_pkg::*; #(
  parameter  int MAX_ROWS    = 32,
  parameter  int MAX_COLUMNS = 128,
  localparam int CR_W        = $clog2(MAX_ROWS + 1),
  localparam int CC_W        = $clog2(MAX_COLUMNS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [CR_W-1:0]       eff_rows,
  output logic [CC_W-1:0]       eff_cols,
  output logic                  clamp_req
);

  logic [ROWS_CFG_W-1:0] rows_r;
  logic [COLS_CFG_W-1:0] cols_r;
  logic                  clamp_r;
  logic                  wr_en;
  reg_idx_t              reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= ROWS_RESET;
      cols_r  <= COLUMNS_RESET;
      clamp_r <= 1'b0;
    end else begin
      clamp_r <= wr_en;
      if (wr_en) begin
        unique case (reg_idx)
          REG_ROWS:    rows_r <= pwdata[ROWS_CFG_W-1:0];
          REG_COLUMNS: cols_r <= pwdata[COLS_CFG_W-1:0];
        endcase
      end
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROWS:    prdata = APB_DATA_W'(rows_r);
      REG_COLUMNS: prdata = APB_DATA_W'(cols_r);
    endcase
  end

  // Saturate the counts to 1..MAX.
  always_comb begin
    if (rows_r == '0) begin
      eff_rows = CR_W'(1);
    end else if (32'(rows_r) > MAX_ROWS) begin
      eff_rows = CR_W'(MAX_ROWS);
    end else begin
      eff_rows = CR_W'(rows_r);
    end
    if (cols_r == '0) begin
      eff_cols = CC_W'(1);
    end else if (32'(cols_r) > MAX_COLUMNS) begin
      eff_cols = CC_W'(MAX_COLUMNS);
    end else begin
      eff_cols = CC_W'(cols_r);
    end
  end

  // Pull the cursor back onto the screen in the cycle after a write.
  assign clamp_req = clamp_r;

endmodule

// File: hw/rtl/tccs_put_calc.sv
// ----------------------------------------------------------------------------
// tccs_put_calc
// Cursor update for one item: scroll decision, wrap, newline, the cell to
// store and the cursor that results.
// ----------------------------------------------------------------------------
module tccs_put_calc import tccs_pkg::*; #(
  parameter  int MAX_ROWS    = 32,
  parameter  int MAX_COLUMNS = 128,
  localparam int ROW_W       = $clog2(MAX_ROWS),
  localparam int COL_W       = $clog2(MAX_COLUMNS),
  localparam int CR_W        = $clog2(MAX_ROWS + 1),
  localparam int CC_W        = $clog2(MAX_COLUMNS + 1)
) (
  input  op_t               op,
  input  logic [CODE_W-1:0] char_code,
  input  logic [CR_W-1:0]   cur_row,
  input  logic [CC_W-1:0]   cur_col,
  input  logic [CR_W-1:0]   eff_rows,
  input  logic [CC_W-1:0]   eff_cols,
  output logic [CR_W-1:0]   row_nxt,
  output logic [CC_W-1:0]   col_nxt,
  output logic [ROW_W-1:0]  wr_row,
  output logic [COL_W-1:0]  wr_col,
  output logic [CODE_W-1:0] wr_code,
  output put_flags_t        flags
);

  logic [CR_W-1:0] row_c, r1, r2, r3;
  logic [CC_W-1:0] col_c, col0, c1, c2;
  logic            is_put, s1, s2, wrap;

  always_comb begin
    row_c   = (cur_row > eff_rows) ? eff_rows : cur_row;
    col_c   = (cur_col > eff_cols) ? eff_cols : cur_col;
    is_put  = (op == OP_PUT) || (op == OP_BACKSPACE);
    wr_code = (op == OP_PUT) ? char_code : CODE_SPACE;
    // Backspace steps back before putting its space.
    col0    = ((op == OP_BACKSPACE) && (col_c != '0)) ? col_c - CC_W'(1) : col_c;
    // Cursor parked below the last row: scroll first.
    s1      = (row_c >= eff_rows);
    r1      = s1 ? eff_rows - CR_W'(1) : row_c;
    c1      = s1 ? '0 : col0;
    // Wrap at the right edge; scroll at once when that leaves the screen.
    wrap    = (c1 >= eff_cols);
    r2      = wrap ? r1 + CR_W'(1) : r1;
    c2      = wrap ? '0 : c1;
    s2      = wrap && (r2 >= eff_rows);
    r3      = s2 ? eff_rows - CR_W'(1) : r2;

    wr_row  = ROW_W'(r3);
    wr_col  = COL_W'(c2);
    row_nxt = row_c;
    col_nxt = col_c;
    flags   = '0;
    if (is_put) begin
      if ((op == OP_PUT) && (char_code == CODE_NEWLINE)) begin
        row_nxt      = r1 + CR_W'(1);
        col_nxt      = '0;
        flags.scroll = s1;
      end else begin
        row_nxt          = r3;
        // Backspace steps back again over the space it put.
        col_nxt          = (op == OP_BACKSPACE) ? c2 : c2 + CC_W'(1);
        flags.scroll     = s1 || s2;
        flags.write_cell = 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/text_console_cell_store.sv
// ----------------------------------------------------------------------------
// text_console_cell_store
// Character-cell text console: a MAX_ROWS x MAX_COLUMNS store of 8-bit
// codes with a cursor, put character, backspace, cell read and scroll.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole cell memory to spaces, one cell a
// cycle, and takes no item meanwhile; register writes are taken at any
// time. Items are handled one at a time and each gives one result item. A
// put or backspace that does not scroll hands its result straight to the
// output register when it is free; a cell read goes through the read and
// result states. A scroll copies every screen row below the top one a row
// up and blanks the bottom row through the single write port of the cell
// memory, then stores the held-back code. A finished result waits in the
// output register while the next item is accepted. Registers: 0
// rows_in_use at byte 0, 1 columns_in_use at byte 4; counts saturate to
// 1..MAX, and the cursor is pulled back onto the screen in the cycle after
// a write.
// ----------------------------------------------------------------------------
`include "text_console_cell_store_defines.svh"

module text_console_cell_store import tccs_pkg::*; #(
  parameter int MAX_ROWS    = 32,
  parameter int MAX_COLUMNS = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tccs_in_if.sink               in_chan,
  tccs_out_if.source            out_chan,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLUMNS);
  localparam int CR_W      = $clog2(MAX_ROWS + 1);
  localparam int CC_W      = $clog2(MAX_COLUMNS + 1);
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int MEM_DEPTH = MAX_ROWS * (2 ** COL_W);

  typedef enum logic [3:0] {
    ST_CLEAR,   // sweep the memory to spaces after reset
    ST_IDLE,    // wait for an item
    ST_EXEC,    // update cursor, store the code or start a read or scroll
    ST_READ,    // pick up the read cell
    ST_COPY,    // move screen rows up by one
    ST_DRAIN,   // write back the last copied cell
    ST_FILL,    // blank the bottom screen row
    ST_WRITE,   // store the code held back behind the scroll
    ST_RESULT   // hand the result to the output register
  } state_t;

  // Control state.
  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [CR_W-1:0]     cur_row_r, cur_row_nxt;
  logic [CC_W-1:0]     cur_col_r, cur_col_nxt;
  logic                cp_valid_r, cp_valid_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Payload.
  op_t                 item_op_r, item_op_nxt;
  logic [CODE_W-1:0]   item_code_r, item_code_nxt;
  logic [RROW_W-1:0]   item_rrow_r, item_rrow_nxt;
  logic [RCOL_W-1:0]   item_rcol_r, item_rcol_nxt;
  logic [ROW_W-1:0]    sr_r, sr_nxt;
  logic [COL_W-1:0]    sc_r, sc_nxt;
  logic [ADDR_W-1:0]   cp_addr_r, cp_addr_nxt;
  logic                pend_we_r, pend_we_nxt;
  logic [ADDR_W-1:0]   pend_addr_r, pend_addr_nxt;
  logic [CODE_W-1:0]   pend_code_r, pend_code_nxt;
  logic [CODE_W-1:0]   res_cell_r, res_cell_nxt;
  logic                res_scroll_r, res_scroll_nxt;
  logic [CODE_W-1:0]   out_cell_r, out_cell_nxt;
  logic [CROW_W-1:0]   out_row_r, out_row_nxt;
  logic [CCOL_W-1:0]   out_col_r, out_col_nxt;
  logic                out_scroll_r, out_scroll_nxt;

  // Memory ports.
  logic                mem_we, mem_re;
  logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
  logic [CODE_W-1:0]   mem_wdata, mem_rdata;

  // Screen size and the put calculation.
  logic [CR_W-1:0]     eff_rows;
  logic [CC_W-1:0]     eff_cols;
  logic                clamp_req;
  logic [CR_W-1:0]     calc_row;
  logic [CC_W-1:0]     calc_col;
  logic [ROW_W-1:0]    wr_row;
  logic [COL_W-1:0]    wr_col;
  logic [CODE_W-1:0]   wr_code;
  put_flags_t          put_flags;
  logic                rd_in_range;
  logic                out_free;
  logic                last_col;
  logic [ROW_W-1:0]    bottom_row;

  tccs_cfg_regs #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (cfg_psel),
    .penable   (cfg_penable),
    .pwrite    (cfg_pwrite),
    .paddr     (cfg_paddr),
    .pwdata    (cfg_pwdata),
    .prdata    (cfg_prdata),
    .pready    (cfg_pready),
    .eff_rows  (eff_rows),
    .eff_cols  (eff_cols),
    .clamp_req (clamp_req)
  );

  tccs_put_calc #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_calc (
    .op        (item_op_r),
    .char_code (item_code_r),
    .cur_row   (cur_row_r),
    .cur_col   (cur_col_r),
    .eff_rows  (eff_rows),
    .eff_cols  (eff_cols),
    .row_nxt   (calc_row),
    .col_nxt   (calc_col),
    .wr_row    (wr_row),
    .wr_col    (wr_col),
    .wr_code   (wr_code),
    .flags     (put_flags)
  );

  tccs_cell_mem #(
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Reads outside the store return 0.
  assign rd_in_range = (32'(item_rrow_r) < MAX_ROWS) && (32'(item_rcol_r) < MAX_COLUMNS);
  // The output register can take a result in this cycle.
  assign out_free    = !out_valid_r || out_chan.ready;
  // Scroll column counter sits on the last screen column.
  assign last_col    = (CC_W'(sc_r) == eff_cols - CC_W'(1));
  assign bottom_row  = ROW_W'(eff_rows - CR_W'(1));

  assign in_chan.ready              = (state_r == ST_IDLE);
  assign out_chan.valid             = out_valid_r;
  assign out_chan.cell_code         = out_cell_r;
  assign out_chan.cursor_row_now    = out_row_r;
  assign out_chan.cursor_column_now = out_col_r;
  assign out_chan.did_scroll        = out_scroll_r;

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    cp_valid_nxt   = cp_valid_r;
    out_valid_nxt  = out_valid_r;
    item_op_nxt    = item_op_r;
    item_code_nxt  = item_code_r;
    item_rrow_nxt  = item_rrow_r;
    item_rcol_nxt  = item_rcol_r;
    sr_nxt         = sr_r;
    sc_nxt         = sc_r;
    cp_addr_nxt    = cp_addr_r;
    pend_we_nxt    = pend_we_r;
    pend_addr_nxt  = pend_addr_r;
    pend_code_nxt  = pend_code_r;
    res_cell_nxt   = res_cell_r;
    res_scroll_nxt = res_scroll_r;
    out_cell_nxt   = out_cell_r;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    out_scroll_nxt = out_scroll_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = CODE_SPACE;
    mem_re         = 1'b0;
    mem_raddr      = '0;

    // Drop the result once the sink takes it.
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    // Pull the cursor onto a screen that has just shrunk.
    if (clamp_req) begin
      cur_row_nxt = (cur_row_r > eff_rows) ? eff_rows : cur_row_r;
      cur_col_nxt = (cur_col_r > eff_cols) ? eff_cols : cur_col_r;
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = CODE_SPACE;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(MEM_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_chan.valid) begin
          item_op_nxt   = in_chan.op;
          item_code_nxt = in_chan.char_code;
          item_rrow_nxt = in_chan.read_row;
          item_rcol_nxt = in_chan.read_column;
          state_nxt     = ST_EXEC;
        end
      end

      ST_EXEC: begin
        cur_row_nxt    = calc_row;
        cur_col_nxt    = calc_col;
        res_cell_nxt   = '0;
        res_scroll_nxt = put_flags.scroll;
        pend_we_nxt    = put_flags.write_cell;
        pend_addr_nxt  = {wr_row, wr_col};
        pend_code_nxt  = wr_code;
        if (put_flags.scroll) begin
          // Hold the store back until the screen has moved up.
          sr_nxt       = ROW_W'(1);
          sc_nxt       = '0;
          cp_valid_nxt = 1'b0;
          state_nxt    = (eff_rows > CR_W'(1)) ? ST_COPY : ST_FILL;
        end else if (item_op_r == OP_READ) begin
          mem_re    = rd_in_range;
          mem_raddr = {ROW_W'(item_rrow_r), COL_W'(item_rcol_r)};
          state_nxt = ST_READ;
        end else begin
          mem_we    = put_flags.write_cell;
          mem_waddr = {wr_row, wr_col};
          mem_wdata = wr_code;
          // Skip the result state when the output register is free.
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_cell_nxt   = '0;
            out_row_nxt    = CROW_W'(calc_row);
            out_col_nxt    = CCOL_W'(calc_col);
            out_scroll_nxt = 1'b0;
            state_nxt      = ST_IDLE;
          end else begin
            state_nxt = ST_RESULT;
          end
        end
      end

      ST_READ: begin
        res_cell_nxt = rd_in_range ? mem_rdata : '0;
        state_nxt    = ST_RESULT;
      end

      ST_COPY: begin
        // Read one cell a cycle and write it a row up in the next.
        mem_re       = 1'b1;
        mem_raddr    = {sr_r, sc_r};
        mem_we       = cp_valid_r;
        mem_waddr    = cp_addr_r;
        mem_wdata    = mem_rdata;
        cp_valid_nxt = 1'b1;
        cp_addr_nxt  = {ROW_W'(sr_r - ROW_W'(1)), sc_r};
        if (last_col) begin
          sc_nxt = '0;
          if (CR_W'(sr_r) == eff_rows - CR_W'(1)) begin
            state_nxt = ST_DRAIN;
          end else begin
            sr_nxt = sr_r + ROW_W'(1);
          end
        end else begin
          sc_nxt = sc_r + COL_W'(1);
        end
      end

      ST_DRAIN: begin
        mem_we       = cp_valid_r;
        mem_waddr    = cp_addr_r;
        mem_wdata    = mem_rdata;
        cp_valid_nxt = 1'b0;
        sc_nxt       = '0;
        state_nxt    = ST_FILL;
      end

      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = {bottom_row, sc_r};
        mem_wdata = CODE_SPACE;
        if (last_col) begin
          state_nxt = ST_WRITE;
        end else begin
          sc_nxt = sc_r + COL_W'(1);
        end
      end

      ST_WRITE: begin
        mem_we    = pend_we_r;
        mem_waddr = pend_addr_r;
        mem_wdata = pend_code_r;
        state_nxt = ST_RESULT;
      end

      ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_cell_nxt   = res_cell_r;
          out_row_nxt    = CROW_W'(cur_row_r);
          out_col_nxt    = CCOL_W'(cur_col_r);
          out_scroll_nxt = res_scroll_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      cp_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      cp_valid_r  <= cp_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_op_r    <= item_op_nxt;
    item_code_r  <= item_code_nxt;
    item_rrow_r  <= item_rrow_nxt;
    item_rcol_r  <= item_rcol_nxt;
    sr_r         <= sr_nxt;
    sc_r         <= sc_nxt;
    cp_addr_r    <= cp_addr_nxt;
    pend_we_r    <= pend_we_nxt;
    pend_addr_r  <= pend_addr_nxt;
    pend_code_r  <= pend_code_nxt;
    res_cell_r   <= res_cell_nxt;
    res_scroll_r <= res_scroll_nxt;
    out_cell_r   <= out_cell_nxt;
    out_row_r    <= out_row_nxt;
    out_col_r    <= out_col_nxt;
    out_scroll_r <= out_scroll_nxt;
  end

  // An item leaves the cursor on the screen or parked just below it.
  `TCCS_ASSERT(a_cursor_on_screen, clk, rst_n,
    $past(state_r) == ST_EXEC |-> (cur_row_r <= eff_rows && cur_col_r <= eff_cols),
    "cursor off the screen after an item")
  // Only a put or a backspace scrolls.
  `TCCS_ASSERT(a_scroll_only_on_put, clk, rst_n,
    (state_r == ST_EXEC && put_flags.scroll) |->
      (item_op_r == OP_PUT || item_op_r == OP_BACKSPACE),
    "scroll on an item that puts nothing")
  // No result appears before the memory sweep has finished.
  `TCCS_ASSERT(a_no_result_in_clear, clk, rst_n, state_r == ST_CLEAR |-> !out_valid_r,
    "result during the memory sweep")
  // The row copy ends only through the drain cycle.
  `TCCS_ASSERT_NEXT(a_copy_then_drain, clk, rst_n, state_r == ST_COPY,
    state_r == ST_COPY || state_r == ST_DRAIN, "row copy left without draining")

endmodule

// File: tb/tb_text_console_cell_store.sv
// ----------------------------------------------------------------------------
// tb_text_console_cell_store
// Self-checking bench for the character-cell text console. A console model
// inside the bench tracks the cell image, the cursor and both screen-size
// registers, and predicts one result item for every command item. Directed
// tests cover the corners: power-up contents, scroll on put, on wrap and on
// backspace, registers out of range, and a screen shrunk under the cursor.
// Random phases follow on many screen sizes, under bursty input and a
// stalling result receiver.
// ----------------------------------------------------------------------------
module tb_text_console_cell_store;
  import tccs_pkg::*;

  localparam int MAX_ROWS       = 32;
  localparam int MAX_COLUMNS    = 128;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 32;
  // A full-screen scroll and the clearing sweep after reset move nothing on
  // any port while they run, so allow a wide margin over both.
  localparam int WATCHDOG_LIMIT = 50000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 68;

  typedef struct packed {
    logic [CODE_W-1:0] cell_code;
    logic [CROW_W-1:0] row;
    logic [CCOL_W-1:0] column;
    logic              scrolled;
  } console_result_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_SPARSE,
    STALL_LIGHT
  } stall_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [APB_ADDR_W-1:0] cfg_paddr;
  logic [APB_DATA_W-1:0] cfg_pwdata;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  tccs_in_if  in_chan ();
  tccs_out_if out_chan ();

  text_console_cell_store #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Console model: cell image, cursor and the raw register values.
  // --------------------------------------------------------------------------
  logic [CODE_W-1:0]     cell_image [MAX_ROWS][MAX_COLUMNS];
  int unsigned           cursor_row;
  int unsigned           cursor_column;
  logic [ROWS_CFG_W-1:0] rows_reg;
  logic [COLS_CFG_W-1:0] columns_reg;

  // Results still owed by the block, oldest first.
  console_result_t owed_results [$];

  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned scrolls_seen;
  int unsigned register_writes;
  int unsigned burst_left;
  int unsigned stuck_cycles;

  function automatic void clear_console();
    for (int r = 0; r < MAX_ROWS; r++) begin
      for (int c = 0; c < MAX_COLUMNS; c++) cell_image[r][c] = CODE_SPACE;
    end
    cursor_row    = 0;
    cursor_column = 0;
    rows_reg      = ROWS_RESET;
    columns_reg   = COLUMNS_RESET;
  endfunction

  // Register values saturate to 1..MAX when used.
  function automatic int unsigned screen_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > MAX_ROWS) return MAX_ROWS;
    return rows_reg;
  endfunction

  function automatic int unsigned screen_columns();
    if (columns_reg == 0) return 1;
    if (columns_reg > MAX_COLUMNS) return MAX_COLUMNS;
    return columns_reg;
  endfunction

  function automatic void pull_cursor_onto_screen();
    if (cursor_row > screen_rows()) cursor_row = screen_rows();
    if (cursor_column > screen_columns()) cursor_column = screen_columns();
  endfunction

  // Move screen rows up by one and blank the bottom one; off-screen cells hold.
  function automatic void scroll_screen();
    int unsigned nr;
    int unsigned nc;
    nr = screen_rows();
    nc = screen_columns();
    for (int unsigned r = 1; r < nr; r++) begin
      for (int unsigned c = 0; c < nc; c++) cell_image[r-1][c] = cell_image[r][c];
    end
    for (int unsigned c = 0; c < nc; c++) cell_image[nr-1][c] = CODE_SPACE;
  endfunction

  // Put one code at the cursor; return 1 when the screen scrolled.
  function automatic logic put_code(logic [CODE_W-1:0] code);
    int unsigned nr;
    int unsigned nc;
    logic        scrolled;
    nr       = screen_rows();
    nc       = screen_columns();
    scrolled = 1'b0;
    // A cursor parked below the last row scrolls before anything else.
    if (cursor_row >= nr) begin
      scroll_screen();
      cursor_row    = nr - 1;
      cursor_column = 0;
      scrolled      = 1'b1;
    end
    if (code == CODE_NEWLINE) begin
      // Newline may park the cursor at row R; the scroll waits for the next put.
      cursor_column = 0;
      cursor_row++;
      return scrolled;
    end
    if (cursor_column >= nc) begin
      // Wrap; a wrap past the last row scrolls at once.
      cursor_column = 0;
      cursor_row++;
      if (cursor_row >= nr) begin
        scroll_screen();
        cursor_row = nr - 1;
        scrolled   = 1'b1;
      end
    end
    cell_image[cursor_row][cursor_column] = code;
    cursor_column++;
    return scrolled;
  endfunction

  function automatic console_result_t predict_console(op_t op, logic [CODE_W-1:0] code,
                                                      logic [RROW_W-1:0] rr,
                                                      logic [RCOL_W-1:0] rc);
    console_result_t res;
    res = '0;
    pull_cursor_onto_screen();
    case (op)
      OP_PUT: res.scrolled = put_code(code);
      OP_BACKSPACE: begin
        // Step back, blank the cell like a put would, step back again.
        if (cursor_column != 0) cursor_column--;
        res.scrolled = put_code(CODE_SPACE);
        if (cursor_column != 0) cursor_column--;
      end
      OP_READ: res.cell_code = cell_image[rr][rc];
      default: ;
    endcase
    res.row    = CROW_W'(cursor_row);
    res.column = CCOL_W'(cursor_column);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Reporting and result checking.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Compare every result item taken from the block with the oldest one owed.
  always @(posedge clk) begin
    console_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (owed_results.size() == 0) begin
        report_mismatch("result item with none outstanding", results_seen, items_sent);
      end else begin
        want = owed_results.pop_front();
        if (out_chan.cell_code !== want.cell_code)
          report_mismatch("cell_code", out_chan.cell_code, want.cell_code);
        if (out_chan.cursor_row_now !== want.row)
          report_mismatch("cursor_row_now", out_chan.cursor_row_now, want.row);
        if (out_chan.cursor_column_now !== want.column)
          report_mismatch("cursor_column_now", out_chan.cursor_column_now, want.column);
        if (out_chan.did_scroll !== want.scrolled)
          report_mismatch("did_scroll", out_chan.did_scroll, want.scrolled);
        if (want.scrolled) scrolls_seen++;
      end
    end
  end

  // Count cycles in which nothing moves on any port; give up at the limit.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_psel && cfg_penable)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no progress for %0d cycles", $time, stuck_cycles);
      $display("text_console_cell_store test failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Result receiver: switch at random intervals between stall patterns,
  // one of which never stalls.
  initial begin
    stall_mode_t mode;
    int unsigned left;
    int unsigned phase;
    out_chan.ready <= 1'b0;
    mode  = STALL_NONE;
    left  = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
        left = $urandom_range(16, 96);
      end
      left--;
      phase++;
      case (mode)
        STALL_NONE:   out_chan.ready <= 1'b1;
        STALL_COIN:   out_chan.ready <= ($urandom_range(0, 1) == 1);
        STALL_SPARSE: out_chan.ready <= (phase % 4 == 0);
        default:      out_chan.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Drivers.
  // --------------------------------------------------------------------------

  // Send one command item; open a fresh burst with a random gap when the
  // current burst is used up, and log the predicted result on accept.
  task automatic send_item(op_t op, logic [CODE_W-1:0] code, logic [RROW_W-1:0] rr,
                           logic [RCOL_W-1:0] rc);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      // Drop valid only when a real gap follows, so it never dips within one step.
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_chan.valid       <= 1'b1;
    in_chan.op          <= op;
    in_chan.char_code   <= code;
    in_chan.read_row    <= rr;
    in_chan.read_column <= rc;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    owed_results.push_back(predict_console(op, code, rr, rc));
    items_sent++;
    burst_left--;
  endtask

  // Random item: mostly puts, with reads aimed at the screen most of the time.
  task automatic send_random_item(int unsigned newline_pct);
    op_t               op;
    logic [CODE_W-1:0] code;
    logic [RROW_W-1:0] rr;
    logic [RCOL_W-1:0] rc;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) op = OP_PUT;
    else if (pick < 75) op = OP_BACKSPACE;
    else if (pick < 95) op = OP_READ;
    else op = OP_NONE;
    code = ($urandom_range(0, 99) < newline_pct) ? CODE_NEWLINE
                                                 : CODE_W'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) begin
      rr = RROW_W'($urandom_range(0, MAX_ROWS - 1));
      rc = RCOL_W'($urandom_range(0, MAX_COLUMNS - 1));
    end else begin
      rr = RROW_W'($urandom_range(0, screen_rows() - 1));
      rc = RCOL_W'($urandom_range(0, screen_columns() - 1));
    end
    send_item(op, code, rr, rc);
  endtask

  // Stop sending, wait for every owed result, then let the block settle.
  task automatic wait_until_idle();
    in_chan.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle. Upper data bits carry junk that
  // the register must drop.
  task automatic write_register(reg_idx_t idx, int unsigned value);
    logic [APB_DATA_W-1:0] word;
    word = $urandom;
    if (idx == REG_ROWS) word[ROWS_CFG_W-1:0] = value[ROWS_CFG_W-1:0];
    else word[COLS_CFG_W-1:0] = value[COLS_CFG_W-1:0];
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_ROWS) rows_reg = word[ROWS_CFG_W-1:0];
    else columns_reg = word[COLS_CFG_W-1:0];
    pull_cursor_onto_screen();
    register_writes++;
    // The block pulls its cursor back in the cycle after the write.
    repeat (2) @(posedge clk);
  endtask

  task automatic set_screen(int unsigned rows, int unsigned columns);
    wait_until_idle();
    if ($urandom_range(0, 1) == 1) begin
      write_register(REG_ROWS, rows);
      write_register(REG_COLUMNS, columns);
    end else begin
      write_register(REG_COLUMNS, columns);
      write_register(REG_ROWS, rows);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Default 28 x 84 screen straight out of reset: blank cells, code extremes,
  // backspace at column 0, the unused op, and junk in ignored fields.
  task automatic test_power_up();
    send_item(OP_READ, 8'hFF, 5'd0, 7'd0);
    send_item(OP_READ, 8'h00, 5'd31, 7'd127);
    send_item(OP_PUT, 8'h00, 5'h1F, 7'h7F);
    send_item(OP_PUT, 8'hFF, 5'h1F, 7'h7F);
    send_item(OP_PUT, CODE_NEWLINE, 5'd0, 7'd0);
    send_item(OP_BACKSPACE, 8'hFF, 5'h1F, 7'h7F);
    send_item(OP_NONE, 8'hFF, 5'h1F, 7'h7F);
    send_item(OP_READ, 8'h00, 5'd0, 7'd1);
  endtask

  // 2 x 4 screen: scroll held back after a newline, scroll at once on a wrap
  // past the last row, and off-screen cells left alone.
  task automatic test_scroll_paths();
    set_screen(2, 4);
    send_item(OP_PUT, "a", 5'd0, 7'd0);
    send_item(OP_PUT, "b", 5'd0, 7'd0);
    send_item(OP_PUT, "c", 5'd0, 7'd0);
    send_item(OP_PUT, "d", 5'd0, 7'd0);
    send_item(OP_PUT, "e", 5'd0, 7'd0);
    send_item(OP_PUT, CODE_NEWLINE, 5'd0, 7'd0);
    send_item(OP_PUT, "f", 5'd0, 7'd0);
    send_item(OP_READ, 8'h00, 5'd0, 7'd0);
    repeat (3) send_item(OP_PUT, "g", 5'd0, 7'd0);
    send_item(OP_PUT, "j", 5'd0, 7'd0);
    send_item(OP_READ, 8'h00, 5'd1, 7'd4);
  endtask

  // Zero counts saturate to a 1 x 1 screen; every wrap scrolls, and a
  // backspace with the cursor parked below the screen scrolls too.
  task automatic test_register_limits();
    set_screen(0, 0);
    send_item(OP_PUT, "x", 5'd0, 7'd0);
    send_item(OP_PUT, "y", 5'd0, 7'd0);
    send_item(OP_PUT, CODE_NEWLINE, 5'd0, 7'd0);
    send_item(OP_BACKSPACE, 8'h41, 5'd0, 7'd0);
    send_item(OP_READ, 8'h00, 5'd0, 7'd0);
  endtask

  // Oversized counts saturate to the full 32 x 128 store; drive enough
  // newlines to force at least one full-screen scroll, then random traffic.
  task automatic test_full_screen();
    set_screen(63, 255);
    for (int i = 0; i < 80; i++) begin
      if (i < 34) send_item(OP_PUT, CODE_NEWLINE, RROW_W'($urandom_range(0, 31)),
                            RCOL_W'($urandom_range(0, 127)));
      else send_random_item(10);
    end
  endtask

  // Shrink the screen under a cursor far down and right, then put and erase.
  task automatic test_shrink_under_cursor();
    wait_until_idle();
    write_register(REG_ROWS, 3);
    send_item(OP_PUT, "A", 5'd0, 7'd0);
    wait_until_idle();
    write_register(REG_COLUMNS, 5);
    send_item(OP_BACKSPACE, 8'h00, 5'd0, 7'd0);
    send_item(OP_READ, 8'h00, 5'd2, 7'd0);
  endtask

  // Random phases: mostly small screens so scrolls stay cheap, every fourth
  // phase over the whole register range.
  task automatic test_random_traffic();
    int unsigned rows;
    int unsigned columns;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p % 4 == 3) begin
        rows    = $urandom_range(0, 63);
        columns = $urandom_range(0, 255);
      end else begin
        rows    = $urandom_range(0, 6);
        columns = $urandom_range(0, 12);
      end
      set_screen(rows, columns);
      repeat (PHASE_ITEMS) send_random_item(15);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.op          <= OP_NONE;
    in_chan.char_code   <= '0;
    in_chan.read_row    <= '0;
    in_chan.read_column <= '0;
    cfg_psel            <= 1'b0;
    cfg_penable         <= 1'b0;
    cfg_pwrite          <= 1'b0;
    cfg_paddr           <= '0;
    cfg_pwdata          <= '0;
    mismatches      = 0;
    items_sent      = 0;
    results_seen    = 0;
    scrolls_seen    = 0;
    register_writes = 0;
    burst_left      = 0;
    stuck_cycles    = 0;
    clear_console();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The block sweeps its store after reset; the first item simply waits.
    test_power_up();
    test_scroll_paths();
    test_register_limits();
    test_full_screen();
    test_shrink_under_cursor();
    test_random_traffic();

    // Drain: hold valid low until nothing is owed, then watch for strays.
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d command items and %0d result items, %0d of them scrolls,",
             items_sent, results_seen, scrolls_seen);
    $display("over %0d register writes; %0d mismatches.", register_writes, mismatches);
    if (mismatches == 0) begin
      $display("text_console_cell_store test passed");
    end else begin
      $display("text_console_cell_store test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/tccs_pkg.sv
hw/rtl/tccs_chan_if.sv
hw/rtl/tccs_cell_mem.sv
hw/rtl/tccs_cfg_regs.sv
hw/rtl/tccs_put_calc.sv
hw/rtl/text_console_cell_store.sv
tb/tb_text_console_cell_store.sv
